>>> sv/csba_pkg.sv
// ----------------------------------------------------------------------------
// csba_pkg
// Shared types and constants of the contiguous slot bitmap allocator.
// ----------------------------------------------------------------------------
package csba_pkg;

  localparam int CAPACITY = 1024;
  localparam int WORD_W   = 32;
  localparam int WORDS    = CAPACITY / WORD_W;
  localparam int WADDR_W  = $clog2(WORDS);
  localparam int BIT_W    = $clog2(WORD_W);
  localparam int IDX_W    = 10;
  localparam int CNT_W    = 11;

  localparam logic [CNT_W-1:0] CAP_SLOTS = 11'd1024;
  localparam logic [CNT_W:0]   CAP_WIDE  = 12'd1024;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic REG_INITIAL_SIZE = 1'b0;
  localparam logic REG_RESERVE_ZERO = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOSPACE    = 2'd1,
    ST_FREED_FREE = 2'd2,
    ST_RANGE      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_GROW,
    S_MARK,
    S_FREE
  } state_t;

  typedef struct packed {
    logic             command;
    logic [IDX_W-1:0] first_slot;
    logic [CNT_W-1:0] count;
  } request_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_index;
    status_t          status;
    logic [CNT_W-1:0] used_total;
    logic [CNT_W-1:0] active_slots;
  } result_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] end_pos;
    logic [CNT_W-1:0] run_out;
  } scan_t;

endpackage

>>> sv/csba_ram.sv
// ----------------------------------------------------------------------------
// csba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module csba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/csba_scan.sv
// ----------------------------------------------------------------------------
// csba_scan
// Evaluates one map word of a free-run search: finds the first slot at which
// the run of free slots reaches the requested count, and the run carried out.
// ----------------------------------------------------------------------------
module csba_scan (
  input  logic [csba_pkg::WORD_W-1:0]  word,
  input  logic [csba_pkg::WADDR_W-1:0] word_idx,
  input  logic [csba_pkg::CNT_W-1:0]   hint,
  input  logic [csba_pkg::CNT_W-1:0]   active,
  input  logic [csba_pkg::CNT_W-1:0]   run_in,
  input  logic [csba_pkg::CNT_W-1:0]   count,
  output csba_pkg::scan_t              res
);

  localparam int WW = csba_pkg::WORD_W;
  localparam int BW = csba_pkg::BIT_W;
  localparam int CW = csba_pkg::CNT_W;

  logic [WW-1:0] blocked;
  logic [WW-1:0] hits;
  logic [BW:0]   last_blk [BW+1][WW];
  logic [CW:0]   run [WW];
  logic [CW-1:0] pos [WW];
  logic [BW-1:0] first;

  always_comb begin
    for (int j = 0; j < WW; j++) begin
      pos[j]     = {1'b0, word_idx, j[BW-1:0]};
      blocked[j] = word[j] | (pos[j] < hint) | (pos[j] >= active);
      last_blk[0][j] = {blocked[j], j[BW-1:0]};
    end
    // prefix search for the nearest blocking slot at or below each bit
    for (int s = 0; s < BW; s++) begin
      for (int j = 0; j < WW; j++) begin
        if (!last_blk[s][j][BW] && j >= (1 << s)) begin
          last_blk[s+1][j] = last_blk[s][j - (1 << s)];
        end else begin
          last_blk[s+1][j] = last_blk[s][j];
        end
      end
    end
    for (int j = 0; j < WW; j++) begin
      if (last_blk[BW][j][BW]) begin
        run[j] = {{(CW+1-BW){1'b0}}, j[BW-1:0]}
               - {{(CW+1-BW){1'b0}}, last_blk[BW][j][BW-1:0]};
      end else begin
        run[j] = {1'b0, run_in} + {{(CW+1-BW){1'b0}}, j[BW-1:0]} + 1'b1;
      end
      hits[j] = (run[j] >= {1'b0, count}) && (pos[j] < active);
    end
    first = '0;
    for (int j = WW - 1; j >= 0; j--) begin
      if (hits[j]) begin
        first = j[BW-1:0];
      end
    end
    res.hit     = |hits;
    res.end_pos = {word_idx, first};
    res.run_out = run[WW-1][CW-1:0];
  end

endmodule

>>> sv/contiguous_slot_bitmap_allocator_top.sv
// ----------------------------------------------------------------------------
// contiguous_slot_bitmap_allocator_top
// Next-fit allocator of contiguous slot runs over a used-bit map held in a
// 32-word RAM, with power-of-two growth of the active size and run release.
// ----------------------------------------------------------------------------
// Flow after acceptance: allocate scans map words from the hint when the hint lies
// below the active size, takes a growth step when no run is found that way, then
// marks the words of the run and returns the result; release clears the words it
// touches; a zero count or an out-of-range release returns its result from idle.
// One beat at a time, one map word per cycle; busy drops as done pulses.
// Reset or any register write restores the reset map at once through per-word valid bits.
module contiguous_slot_bitmap_allocator_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  csba_pkg::request_t request,
  output logic               done,
  output csba_pkg::result_t  result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int WW  = csba_pkg::WORD_W;
  localparam int AW  = csba_pkg::WADDR_W;
  localparam int BW  = csba_pkg::BIT_W;
  localparam int CW  = csba_pkg::CNT_W;
  localparam int IW  = csba_pkg::IDX_W;
  localparam int NW  = csba_pkg::WORDS;

  function automatic logic [CW:0] pow2_ceil(input logic [CW:0] x);
    logic [CW:0] y;
    y = x - 1'b1;
    y = y | (y >> 1);
    y = y | (y >> 2);
    y = y | (y >> 4);
    y = y | (y >> 8);
    return y + 1'b1;
  endfunction

  function automatic logic [CW-1:0] clamp_size(input logic [CW-1:0] v);
    if (v == '0) begin
      return {{(CW-1){1'b0}}, 1'b1};
    end else if (v > csba_pkg::CAP_SLOTS) begin
      return csba_pkg::CAP_SLOTS;
    end
    return v;
  endfunction

  csba_pkg::state_t state, state_next;

  logic [AW-1:0]    cur, cur_next;
  logic             pend, pend_next;
  logic [CW-1:0]    run, run_next;
  logic [CW-1:0]    count_q, count_q_next;
  logic [CW-1:0]    span_lo, span_lo_next;
  logic [CW-1:0]    span_hi, span_hi_next;
  logic [CW-1:0]    active, active_next;
  logic [CW-1:0]    hint, hint_next;
  logic [CW-1:0]    used, used_next;
  logic [CW-1:0]    cfg_size, cfg_size_next;
  logic             cfg_reserve, cfg_reserve_next;
  logic [NW-1:0]    row_valid, row_valid_next;
  logic             rd_valid, rd_row0;
  csba_pkg::result_t result_next;
  logic             done_next;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [WW-1:0]    ram_wdata, ram_rdata;

  logic [WW-1:0]    data_eff;
  csba_pkg::scan_t  scan;
  logic             accept, cfg_wr;
  logic [CW:0]      rel_end, grow_sum, add_sum;
  logic             nospace;
  logic [CW:0]      grown;
  logic [AW:0]      cur_inc;
  logic [CW-1:0]    next_base, hi_m1, run_start;
  logic             last_word;
  logic [WW-1:0]    span_mask, bad, below_bad;

  assign busy   = (state != csba_pkg::S_IDLE);
  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == csba_pkg::REG_RESERVE_ZERO)
                ? {31'd0, cfg_reserve} : {{(32-CW){1'b0}}, cfg_size};

  csba_ram #(.WIDTH(WW), .DEPTH(NW)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // a word never written since restart reads as the reset map
  assign data_eff = rd_valid ? ram_rdata
                  : {{(WW-1){1'b0}}, rd_row0 & cfg_reserve};

  csba_scan u_scan (
    .word     (data_eff),
    .word_idx (cur),
    .hint     (hint),
    .active   (active),
    .run_in   (run),
    .count    (count_q),
    .res      (scan)
  );

  always_comb begin
    rel_end   = {2'b0, request.first_slot} + {1'b0, request.count};
    grow_sum  = {1'b0, active} + {1'b0, count_q};
    nospace   = grow_sum > csba_pkg::CAP_WIDE;
    grown     = pow2_ceil(grow_sum);
    add_sum   = {1'b0, used} + {1'b0, count_q};
    cur_inc   = {1'b0, cur} + 1'b1;
    next_base = {cur_inc, {BW{1'b0}}};
    hi_m1     = span_hi - 1'b1;
    last_word = (cur == hi_m1[IW-1:BW]);
    run_start = {1'b0, scan.end_pos} + 1'b1 - count_q;
    for (int j = 0; j < WW; j++) begin
      span_mask[j] = ({1'b0, cur, j[BW-1:0]} >= span_lo)
                  && ({1'b0, cur, j[BW-1:0]} < span_hi);
    end
    bad       = ~data_eff & span_mask;
    below_bad = (bad - 1'b1) & ~bad;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      csba_pkg::S_IDLE: begin
        if (accept && request.count != '0) begin
          if (request.command == csba_pkg::CMD_ALLOC) begin
            state_next = (hint >= active) ? csba_pkg::S_GROW : csba_pkg::S_SCAN;
          end else if (rel_end <= {1'b0, active}) begin
            state_next = csba_pkg::S_FREE;
          end
        end
      end
      csba_pkg::S_SCAN: begin
        if (pend) begin
          if (scan.hit) begin
            state_next = csba_pkg::S_MARK;
          end else if (next_base >= active) begin
            state_next = csba_pkg::S_GROW;
          end
        end
      end
      csba_pkg::S_GROW: begin
        state_next = nospace ? csba_pkg::S_IDLE : csba_pkg::S_MARK;
      end
      csba_pkg::S_MARK: begin
        if (pend && last_word) begin
          state_next = csba_pkg::S_IDLE;
        end
      end
      csba_pkg::S_FREE: begin
        if (pend && (bad != '0 || last_word)) begin
          state_next = csba_pkg::S_IDLE;
        end
      end
      default: state_next = csba_pkg::S_IDLE;
    endcase
  end

  // datapath and map access
  always_comb begin
    cur_next         = cur;
    pend_next        = pend;
    run_next         = run;
    count_q_next     = count_q;
    span_lo_next     = span_lo;
    span_hi_next     = span_hi;
    active_next      = active;
    hint_next        = hint;
    used_next        = used;
    cfg_size_next    = cfg_size;
    cfg_reserve_next = cfg_reserve;
    row_valid_next   = row_valid;
    result_next      = result;
    done_next        = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = cur;
    ram_wdata        = data_eff;
    ram_raddr        = pend ? cur_inc[AW-1:0] : cur;

    unique case (state)
      csba_pkg::S_IDLE: begin
        if (accept) begin
          count_q_next = request.count;
          pend_next    = 1'b0;
          run_next     = '0;
          if (request.count == '0) begin
            result_next = '{result_index: '0, status: csba_pkg::ST_OK,
                            used_total: used, active_slots: active};
            done_next   = 1'b1;
          end else if (request.command == csba_pkg::CMD_ALLOC) begin
            cur_next = hint[IW-1:BW];
          end else if (rel_end > {1'b0, active}) begin
            result_next = '{result_index: '0, status: csba_pkg::ST_RANGE,
                            used_total: used, active_slots: active};
            done_next   = 1'b1;
          end else begin
            span_lo_next = {1'b0, request.first_slot};
            span_hi_next = rel_end[CW-1:0];
            cur_next     = request.first_slot[IW-1:BW];
          end
        end
      end
      csba_pkg::S_SCAN: begin
        if (!pend) begin
          pend_next = 1'b1;
        end else if (scan.hit) begin
          span_lo_next = run_start;
          span_hi_next = {1'b0, scan.end_pos} + 1'b1;
          cur_next     = run_start[IW-1:BW];
          pend_next    = 1'b0;
        end else begin
          cur_next = cur_inc[AW-1:0];
          run_next = scan.run_out;
        end
      end
      csba_pkg::S_GROW: begin
        if (nospace) begin
          result_next = '{result_index: '0, status: csba_pkg::ST_NOSPACE,
                          used_total: used, active_slots: active};
          done_next   = 1'b1;
        end else begin
          span_lo_next = active;
          span_hi_next = grow_sum[CW-1:0];
          active_next  = grown[CW-1:0];
          cur_next     = active[IW-1:BW];
          pend_next    = 1'b0;
        end
      end
      csba_pkg::S_MARK: begin
        if (!pend) begin
          pend_next = 1'b1;
        end else begin
          ram_we              = 1'b1;
          ram_wdata           = data_eff | span_mask;
          row_valid_next[cur] = 1'b1;
          cur_next            = cur_inc[AW-1:0];
          if (last_word) begin
            used_next   = (add_sum > csba_pkg::CAP_WIDE) ? csba_pkg::CAP_SLOTS
                                                         : add_sum[CW-1:0];
            hint_next   = span_hi;
            result_next = '{result_index: span_lo[IW-1:0],
                            status: csba_pkg::ST_OK,
                            used_total: used_next, active_slots: active};
            done_next   = 1'b1;
          end
        end
      end
      csba_pkg::S_FREE: begin
        if (!pend) begin
          pend_next = 1'b1;
        end else begin
          ram_we              = 1'b1;
          row_valid_next[cur] = 1'b1;
          cur_next            = cur_inc[AW-1:0];
          if (bad != '0) begin
            // clear up to the first slot that is already free, then stop
            ram_wdata   = data_eff & ~(span_mask & below_bad);
            result_next = '{result_index: '0, status: csba_pkg::ST_FREED_FREE,
                            used_total: used, active_slots: active};
            done_next   = 1'b1;
          end else begin
            ram_wdata = data_eff & ~span_mask;
            if (last_word) begin
              used_next   = (used > count_q) ? used - count_q : '0;
              hint_next   = (hint > span_lo) ? span_lo : hint;
              result_next = '{result_index: '0, status: csba_pkg::ST_OK,
                              used_total: used_next, active_slots: active};
              done_next   = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase

    // register write: store and restart from the reset map
    if (cfg_wr) begin
      if (paddr[2] == csba_pkg::REG_INITIAL_SIZE) begin
        cfg_size_next = pwdata[CW-1:0];
      end else begin
        cfg_reserve_next = pwdata[0];
      end
      row_valid_next = '0;
      active_next    = (paddr[2] == csba_pkg::REG_INITIAL_SIZE)
                     ? clamp_size(pwdata[CW-1:0]) : clamp_size(cfg_size);
      hint_next      = '0;
      used_next      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= csba_pkg::S_IDLE;
      pend        <= 1'b0;
      row_valid   <= '0;
      active      <= csba_pkg::CAP_SLOTS;
      hint        <= '0;
      used        <= '0;
      cfg_size    <= csba_pkg::CAP_SLOTS;
      cfg_reserve <= 1'b0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      pend        <= pend_next;
      row_valid   <= row_valid_next;
      active      <= active_next;
      hint        <= hint_next;
      used        <= used_next;
      cfg_size    <= cfg_size_next;
      cfg_reserve <= cfg_reserve_next;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    run      <= run_next;
    count_q  <= count_q_next;
    span_lo  <= span_lo_next;
    span_hi  <= span_hi_next;
    result   <= result_next;
    rd_valid <= row_valid[ram_raddr];
    rd_row0  <= (ram_raddr == '0);
  end

endmodule

>>> test/csba_checker.sv
// ----------------------------------------------------------------------------
// csba_checker
// Watches the request, result and register channels of the contiguous slot
// bitmap allocator. A local copy of the used map, hint, total and active size
// predicts every result; results are compared field by field, in order.
// ----------------------------------------------------------------------------
module csba_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  csba_pkg::request_t request,
  input  logic               done,
  input  csba_pkg::result_t  result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_LIMIT = 40;

  logic [csba_pkg::CAPACITY-1:0] slot_used;
  int unsigned                   hint;
  int unsigned                   used;
  int unsigned                   active;
  logic [csba_pkg::CNT_W-1:0]    cfg_size;
  logic                          cfg_reserve;
  csba_pkg::result_t             expected_q[$];
  csba_pkg::result_t             want;
  int unsigned                   beats_seen;

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_LIMIT) begin
      $display("[%0t] allocator check: %s", $realtime, msg);
    end
    errors++;
  endtask

  function automatic void restart_allocator();
    slot_used = '0;
    if (cfg_size == 0) begin
      active = 1;
    end else if (cfg_size > csba_pkg::CAPACITY) begin
      active = csba_pkg::CAPACITY;
    end else begin
      active = cfg_size;
    end
    hint = 0;
    used = 0;
    if (cfg_reserve) begin
      slot_used[0] = 1'b1;
    end
  endfunction

  function automatic csba_pkg::result_t predict_result(input csba_pkg::request_t req);
    csba_pkg::result_t r;
    csba_pkg::status_t st;
    logic              placed;
    int unsigned       n;
    int unsigned       at;
    int unsigned       run;
    int unsigned       grown;
    int unsigned       i;
    n = req.count;
    at = 0;
    st = csba_pkg::ST_OK;
    if (n != 0 && req.command == csba_pkg::CMD_ALLOC) begin
      placed = 1'b0;
      run = 0;
      for (i = hint; i < active && i < csba_pkg::CAPACITY; i++) begin
        run = slot_used[i] ? 0 : run + 1;
        if (run >= n) begin
          at = i + 1 - n;
          placed = 1'b1;
          break;
        end
      end
      if (!placed) begin
        // grow to the power of two that holds the run past the old end
        grown = 1;
        while (grown < active + n) begin
          grown = grown << 1;
        end
        if (grown <= csba_pkg::CAPACITY) begin
          at = active;
          active = grown;
          placed = 1'b1;
        end else begin
          st = csba_pkg::ST_NOSPACE;
        end
      end
      if (placed) begin
        for (i = at; i < at + n && i < csba_pkg::CAPACITY; i++) begin
          slot_used[i] = 1'b1;
        end
        used = (used + n > csba_pkg::CAPACITY) ? csba_pkg::CAPACITY : used + n;
        hint = at + n;
      end
    end else if (n != 0) begin
      if (req.first_slot + n > active) begin
        st = csba_pkg::ST_RANGE;
      end else begin
        // clear in order; stop at the first slot that is already free
        for (i = req.first_slot; i < req.first_slot + n && i < csba_pkg::CAPACITY;
             i++) begin
          if (!slot_used[i]) begin
            st = csba_pkg::ST_FREED_FREE;
            break;
          end
          slot_used[i] = 1'b0;
        end
        if (st == csba_pkg::ST_OK) begin
          used = (used > n) ? used - n : 0;
          if (hint > req.first_slot) begin
            hint = req.first_slot;
          end
        end
      end
    end
    r.result_index = csba_pkg::IDX_W'(at);
    r.status       = st;
    r.used_total   = csba_pkg::CNT_W'(used);
    r.active_slots = csba_pkg::CNT_W'(active);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg_size = csba_pkg::CAP_SLOTS;
      cfg_reserve = 1'b0;
      restart_allocator();
      expected_q.delete();
      beats_seen = 0;
    end else begin
      // pop before push: a new beat can be taken at the edge that ends a result
      if (done) begin
        beats_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result beat %0d with no request outstanding",
                                    beats_seen));
        end else begin
          want = expected_q.pop_front();
          if (result.result_index !== want.result_index) begin
            report_mismatch($sformatf("beat %0d result_index %0d, expected %0d",
                                      beats_seen, result.result_index, want.result_index));
          end
          if (result.status !== want.status) begin
            report_mismatch($sformatf("beat %0d status %0d, expected %0d",
                                      beats_seen, result.status, want.status));
          end
          if (result.used_total !== want.used_total) begin
            report_mismatch($sformatf("beat %0d used_total %0d, expected %0d",
                                      beats_seen, result.used_total, want.used_total));
          end
          if (result.active_slots !== want.active_slots) begin
            report_mismatch($sformatf("beat %0d active_slots %0d, expected %0d",
                                      beats_seen, result.active_slots, want.active_slots));
          end
        end
      end
      if (start && !busy) begin
        expected_q.push_back(predict_result(request));
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == csba_pkg::REG_INITIAL_SIZE) begin
            cfg_size = pwdata[csba_pkg::CNT_W-1:0];
          end else begin
            cfg_reserve = pwdata[0];
          end
          restart_allocator();
        end else if (paddr[2] == csba_pkg::REG_INITIAL_SIZE) begin
          if (prdata[csba_pkg::CNT_W-1:0] !== cfg_size) begin
            report_mismatch($sformatf("initial_size reads %0d, expected %0d",
                                      prdata[csba_pkg::CNT_W-1:0], cfg_size));
          end
        end else if (prdata[0] !== cfg_reserve) begin
          report_mismatch($sformatf("reserve_slot_zero reads %0d, expected %0d",
                                    prdata[0], cfg_reserve));
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

>>> test/tb_contiguous_slot_bitmap_allocator_top.sv
// ----------------------------------------------------------------------------
// tb_contiguous_slot_bitmap_allocator_top
// Drives allocate and release commands and register writes into the slot
// allocator: a directed opening, then random phases under several register
// settings, allocations mixed with releases of runs that were really handed out, and noise.
// ----------------------------------------------------------------------------
module tb_contiguous_slot_bitmap_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASE_ITEMS   = 140;
  localparam int PHASES        = 8;
  localparam int SETTLE_CYCLES = 80;

  typedef struct {
    int unsigned base;
    int unsigned len;
  } run_t;

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               start   = 1'b0;
  csba_pkg::request_t request = '0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [2:0]         paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic               busy;
  logic               done;
  csba_pkg::result_t  result;
  logic [31:0]        prdata;
  logic               pready;
  int                 errors;
  int                 pending;

  int unsigned        cycles     = 0;
  int unsigned        burst_left = 0;
  csba_pkg::request_t issued_q[$];
  csba_pkg::request_t finished;
  run_t               live[$];

  logic [csba_pkg::CNT_W-1:0] size_plan [PHASES] = '{11'd16, 11'd0, 11'd2047, 11'd1024,
                                                     11'd100, 11'd1, 11'd513, 11'd1024};
  logic                       reserve_plan [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1,
                                                        1'b0, 1'b0, 1'b1, 1'b0};

  contiguous_slot_bitmap_allocator_top dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  csba_checker u_check (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .errors  (errors),
    .pending (pending)
  );

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_contiguous_slot_bitmap_allocator_top NOT OK");
      $finish;
    end
  end

  // Track runs that were handed out so releases can target them.
  always @(posedge clk) begin
    if (!rst && done && issued_q.size() > 0) begin
      finished = issued_q.pop_front();
      if (finished.command == csba_pkg::CMD_ALLOC && finished.count != 0
          && result.status == csba_pkg::ST_OK) begin
        live.push_back(run_t'{base: result.result_index, len: finished.count});
      end
    end
  end

  function automatic csba_pkg::request_t req(input logic cmd, input int unsigned base,
                                             input int unsigned n);
    csba_pkg::request_t r;
    r.command    = cmd;
    r.first_slot = csba_pkg::IDX_W'(base);
    r.count      = csba_pkg::CNT_W'(n);
    return r;
  endfunction

  function automatic csba_pkg::request_t pick_request();
    csba_pkg::request_t r;
    run_t               pick;
    int unsigned        roll;
    int unsigned        k;
    int unsigned        n;
    roll = $urandom_range(99);
    k = $urandom_range(99);
    if (k < 70) begin
      n = $urandom_range(8, 1);
    end else if (k < 90) begin
      n = $urandom_range(64, 9);
    end else if (k < 98) begin
      n = $urandom_range(256, 65);
    end else begin
      n = $urandom_range(1024, 257);
    end
    r.command = csba_pkg::CMD_ALLOC;
    r.first_slot = csba_pkg::IDX_W'($urandom_range(1023));
    if (roll >= 50 && roll < 85 && live.size() > 0) begin
      k = $urandom_range(live.size() - 1);
      pick = live[k];
      live.delete(k);
      r.command = csba_pkg::CMD_RELEASE;
      r.first_slot = csba_pkg::IDX_W'(pick.base);
      n = pick.len;
      // now and then free only the head and keep the tail live
      if (pick.len > 1 && $urandom_range(9) == 0) begin
        n = $urandom_range(pick.len - 1, 1);
        live.push_back(run_t'{base: pick.base + n, len: pick.len - n});
      end
    end else if (roll >= 85) begin
      r.command = ($urandom_range(1) == 0) ? csba_pkg::CMD_ALLOC : csba_pkg::CMD_RELEASE;
      case ($urandom_range(3))
        0:       n = 0;
        1:       n = $urandom_range(16, 1);
        default: n = $urandom_range(2047);
      endcase
    end
    r.count = csba_pkg::CNT_W'(n);
    return r;
  endfunction

  task automatic issue(input csba_pkg::request_t r);
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(9);
      if ($urandom_range(19) == 0) begin
        burst_left = $urandom_range(40, 10);
      end
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    // hold the beat until an edge sees busy low
    do @(posedge clk); while (busy);
    issued_q.push_back(r);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [csba_pkg::CNT_W-1:0] size, input logic reserve);
    logic [31:0] word;
    wait_idle();
    // upper bits are don't-care; fill them with noise
    word = $urandom;
    word[csba_pkg::CNT_W-1:0] = size;
    apb_access(1'b1, {csba_pkg::REG_INITIAL_SIZE, 2'b00}, word);
    word = $urandom;
    word[0] = reserve;
    apb_access(1'b1, {csba_pkg::REG_RESERVE_ZERO, 2'b00}, word);
    apb_access(1'b0, {csba_pkg::REG_INITIAL_SIZE, 2'b00}, '0);
    apb_access(1'b0, {csba_pkg::REG_RESERVE_ZERO, 2'b00}, '0);
    live.delete();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_access(1'b0, {csba_pkg::REG_INITIAL_SIZE, 2'b00}, '0);
    apb_access(1'b0, {csba_pkg::REG_RESERVE_ZERO, 2'b00}, '0);

    // full-size map, no reserved slot
    issue(req(csba_pkg::CMD_ALLOC, 0, 0));
    issue(req(csba_pkg::CMD_RELEASE, 1023, 0));
    issue(req(csba_pkg::CMD_ALLOC, 0, 1));
    issue(req(csba_pkg::CMD_ALLOC, 0, 5));
    issue(req(csba_pkg::CMD_RELEASE, 1, 5));
    issue(req(csba_pkg::CMD_RELEASE, 1, 1));
    issue(req(csba_pkg::CMD_RELEASE, 1020, 10));
    issue(req(csba_pkg::CMD_RELEASE, 1023, 1));
    issue(req(csba_pkg::CMD_ALLOC, 0, 1024));
    issue(req(csba_pkg::CMD_RELEASE, 0, 1));
    issue(req(csba_pkg::CMD_ALLOC, 0, 1024));
    issue(req(csba_pkg::CMD_ALLOC, 0, 1));
    issue(req(csba_pkg::CMD_RELEASE, 512, 512));
    issue(req(csba_pkg::CMD_ALLOC, 1023, 2047));
    issue(req(csba_pkg::CMD_RELEASE, 0, 2047));
    issue(req(csba_pkg::CMD_RELEASE, 1023, 1024));
    issue(req(csba_pkg::CMD_RELEASE, 0, 1024));
    issue(req(csba_pkg::CMD_ALLOC, 0, 3));
    issue(req(csba_pkg::CMD_RELEASE, 0, 1));

    // one active slot, slot zero reserved: growth and total saturation
    configure(11'd1, 1'b1);
    issue(req(csba_pkg::CMD_ALLOC, 0, 1));
    issue(req(csba_pkg::CMD_RELEASE, 0, 2));
    issue(req(csba_pkg::CMD_ALLOC, 0, 3));
    issue(req(csba_pkg::CMD_ALLOC, 0, 2));
    issue(req(csba_pkg::CMD_ALLOC, 0, 100));
    issue(req(csba_pkg::CMD_RELEASE, 7, 1));

    for (int p = 0; p < PHASES; p++) begin
      configure(size_plan[p], reserve_plan[p]);
      repeat (PHASE_ITEMS) issue(pick_request());
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_contiguous_slot_bitmap_allocator_top OK");
    end else begin
      $display("tb_contiguous_slot_bitmap_allocator_top NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
sv/csba_pkg.sv
sv/csba_ram.sv
sv/csba_scan.sv
sv/contiguous_slot_bitmap_allocator_top.sv
test/csba_checker.sv
test/tb_contiguous_slot_bitmap_allocator_top.sv
